// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, status codes and key handling for the linear probing hash
// table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W = 64;
    localparam int SUM_W = 11;
    localparam int SIZE_CFG_W = 11;
    localparam int STATUS_W = 3;
    localparam int SLOT_W = 10;
    localparam int COMPARES_W = 11;

    localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] sum;
    } key_sum_t;

    // The key ends at its first zero byte or after nbytes bytes.
    function automatic key_sum_t normalize_key(input logic [KEY_W-1:0] raw,
                                               input int nbytes);
        key_sum_t   res;
        logic       alive;
        logic [7:0] b;
        res.key = '0;
        res.sum = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            b = raw[8*i +: 8];
            if (i >= nbytes || b == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                res.key[8*i +: 8] = b;
                res.sum = res.sum + SUM_W'(b);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lpht_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_mem
// Slot memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_mem #(
    parameter int DEPTH = 1024,
    parameter int AW = 10,
    parameter int W = 65
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [W-1:0]       rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/lpht_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_hash
// Home slot unit: reduces the byte sum modulo the table size one bit per
// cycle, then steps one slot forward with wrap.
// ----------------------------------------------------------------------------
module lpht_hash
    import lpht_pkg::*;
#(
    parameter int AW = 10,
    parameter int SW = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] sum,
    input  wire logic [SW-1:0]    size,
    output logic                  done,
    output logic [AW-1:0]         home
);

    typedef enum logic {
        H_IDLE,
        H_RUN
    } hstate_t;

    hstate_t          state_reg;
    logic [3:0]       step_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SW-1:0]    size_reg;
    logic [SW-1:0]    rem_reg;
    logic             done_reg;
    logic [SW:0]      shifted;
    logic [SW-1:0]    rem_next;
    logic [SW:0]      plus_one;

    always_comb
    begin
        shifted = {rem_reg, sum_reg[SUM_W-1]};
        if (shifted >= {1'b0, size_reg})
        begin
            rem_next = SW'(shifted - {1'b0, size_reg});
        end
        else
        begin
            rem_next = SW'(shifted);
        end
        plus_one = {1'b0, rem_reg} + (SW+1)'(1);
        if (plus_one == {1'b0, size_reg})
        begin
            home = '0;
        end
        else
        begin
            home = AW'(plus_one);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg   <= sum;
                        size_reg  <= size;
                        rem_reg   <= '0;
                        step_reg  <= 4'(SUM_W - 1);
                        state_reg <= H_RUN;
                    end
                end
                H_RUN:
                begin
                    rem_reg  <= rem_next;
                    sum_reg  <= {sum_reg[SUM_W-2:0], 1'b0};
                    step_reg <= step_reg - 4'd1;
                    if (step_reg == 4'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open addressing hash table with linear probing over one slot memory.
// One operation at a time: start is taken only when idle, and busy stays high
// through the home slot reduction and the slot probes on the one read port.
// After reset the block clears every slot of the memory with busy high.
// The result is shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [SIZE_CFG_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [KEY_W-1:0]      key,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic [SLOT_W-1:0]          slot,
    output logic [COMPARES_W-1:0]      compares
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;
    localparam int MW = KEY_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } state_t;

    state_t                  state_reg;
    logic [SIZE_CFG_W-1:0]   table_size_reg;
    logic [SW-1:0]           size_reg;
    logic [SW-1:0]           size_next;
    logic                    action_reg;
    logic [KEY_W-1:0]        key_reg;
    key_sum_t                norm;
    logic [AW-1:0]           j_reg;
    logic [AW-1:0]           j_step;
    logic [SW-1:0]           cnt_reg;
    logic [SW-1:0]           cnt_inc;
    logic [SW-1:0]           cmp_reg;
    logic                    done_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [AW-1:0]           slot_reg;
    logic [SW-1:0]           compares_reg;
    logic                    accept;
    logic                    hash_done;
    logic [AW-1:0]           hash_home;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [MW-1:0]           mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [MW-1:0]           mem_rdata;
    logic                    used;
    logic                    match;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign norm   = normalize_key(key, KEY_BYTES);

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_next = SW'(1);
        end
        else if (int'(table_size_reg) > TABLE_DEPTH)
        begin
            size_next = SW'(TABLE_DEPTH);
        end
        else
        begin
            size_next = SW'(table_size_reg);
        end
    end

    always_comb
    begin
        if (j_reg == AW'(size_reg - SW'(1)))
        begin
            j_step = '0;
        end
        else
        begin
            j_step = j_reg + AW'(1);
        end
        cnt_inc = cnt_reg + SW'(1);
        used  = mem_rdata[KEY_W];
        match = used && (mem_rdata[KEY_W-1:0] == key_reg);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = j_reg;
        mem_wdata = {1'b1, key_reg};
        mem_raddr = j_step;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_wdata = '0;
        end
        else if (state_reg == S_HASH)
        begin
            mem_raddr = hash_home;
        end
        else if (state_reg == S_PROBE && action_reg == ACT_INSERT && !used)
        begin
            mem_we = 1'b1;
        end
    end

    lpht_hash #(
        .AW(AW),
        .SW(SW)
    ) u_hash (
        .clk(clk),
        .rst_n(rst_n),
        .start(accept),
        .sum(norm.sum),
        .size(size_next),
        .done(hash_done),
        .home(hash_home)
    );

    lpht_mem #(
        .DEPTH(TABLE_DEPTH),
        .AW(AW),
        .W(MW)
    ) u_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            j_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    j_reg <= j_reg + AW'(1);
                    if (j_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg <= action;
                        key_reg    <= norm.key;
                        size_reg   <= size_next;
                        state_reg  <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        j_reg     <= hash_home;
                        cnt_reg   <= '0;
                        cmp_reg   <= '0;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    j_reg   <= j_step;
                    cnt_reg <= cnt_inc;
                    if (action_reg == ACT_INSERT)
                    begin
                        compares_reg <= '0;
                        if (!used)
                        begin
                            status_reg <= ST_ADDED;
                            slot_reg   <= j_reg;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else if (match)
                        begin
                            status_reg <= ST_PRESENT;
                            slot_reg   <= j_reg;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else if (cnt_inc == size_reg)
                        begin
                            status_reg <= ST_FULL;
                            slot_reg   <= '0;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (used)
                        begin
                            cmp_reg <= cmp_reg + SW'(1);
                        end
                        if (match)
                        begin
                            status_reg   <= ST_FOUND;
                            slot_reg     <= j_reg;
                            compares_reg <= cmp_reg + SW'(1);
                            done_reg     <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else if (cnt_inc == size_reg)
                        begin
                            status_reg   <= ST_MISSING;
                            slot_reg     <= '0;
                            compares_reg <= used ? cmp_reg + SW'(1) : cmp_reg;
                            done_reg     <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign slot     = SLOT_W'(slot_reg);
    assign compares = COMPARES_W'(compares_reg);

endmodule
`default_nettype wire

// ===== test/linear_probe_hash_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_tb
// Self-checking bench for the linear probing hash table. Each accepted insert
// or find runs on a shadow copy of the slot memory, which predicts the status,
// slot and compare count of the result. Each done beat is checked against the
// oldest prediction. The run steps through many table sizes, from the
// degenerate ones to sizes above the storage depth.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_tb;
    import lpht_pkg::*;

    localparam int DEPTH = 1024;
    localparam int KEY_BYTES_USED = 8;
    localparam int LIMIT = 8_000_000;
    localparam int TAIL_CYCLES = 1100;
    localparam int NPHASE = 18;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic [COMPARES_W-1:0] compares;
    } table_result_t;

    class hash_table_scoreboard;
        logic [KEY_W-1:0]      slot_key [DEPTH];
        bit                    slot_taken [DEPTH];
        logic [SIZE_CFG_W-1:0] size_setting;
        table_result_t         pending [$];
        int                    mismatches;
        int                    results_checked;
        int                    status_seen [5];

        function new();
            size_setting = SIZE_RESET;
            mismatches = 0;
            results_checked = 0;
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_size(logic [SIZE_CFG_W-1:0] value);
            size_setting = value;
        endfunction

        // Runs one operation on the shadow table and queues its outcome.
        function void note_request(logic act, logic [KEY_W-1:0] raw);
            logic [KEY_W-1:0] k;
            int               sum;
            int               n;
            int               home;
            int               j;
            int               cmp;
            bit               alive;
            bit               hit;
            table_result_t    r;
            k = '0;
            sum = 0;
            alive = 1'b1;
            for (int b = 0; b < KEY_BYTES_USED; b++) begin
                if (raw[8*b +: 8] == 8'd0) alive = 1'b0;
                if (alive) begin
                    k[8*b +: 8] = raw[8*b +: 8];
                    sum += int'(raw[8*b +: 8]);
                end
            end
            if (size_setting == '0) n = 1;
            else if (size_setting > DEPTH) n = DEPTH;
            else n = int'(size_setting);
            home = (sum % n + 1) % n;
            r.status = (act == ACT_INSERT) ? ST_FULL : ST_MISSING;
            r.slot = '0;
            cmp = 0;
            hit = 1'b0;
            for (int i = 0; i < n && !hit; i++) begin
                j = (home + i) % n;
                if (act == ACT_INSERT) begin
                    if (!slot_taken[j]) begin
                        slot_taken[j] = 1'b1;
                        slot_key[j] = k;
                        r.status = ST_ADDED;
                        hit = 1'b1;
                    end
                    else if (slot_key[j] == k) begin
                        r.status = ST_PRESENT;
                        hit = 1'b1;
                    end
                end
                else if (slot_taken[j]) begin
                    cmp++;
                    if (slot_key[j] == k) begin
                        r.status = ST_FOUND;
                        hit = 1'b1;
                    end
                end
                if (hit) r.slot = SLOT_W'(j);
            end
            r.compares = COMPARES_W'(cmp);
            pending.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 25) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                          logic [COMPARES_W-1:0] cmp);
            table_result_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status %0d slot %0d compares %0d",
                                          st, sl, cmp));
            end
            else begin
                want = pending.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (st !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, want.status));
                if (sl !== want.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", sl, want.slot));
                if (cmp !== want.compares)
                    report_mismatch($sformatf("compares %0d, want %0d", cmp, want.compares));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [SIZE_CFG_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [KEY_W-1:0]      key;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [COMPARES_W-1:0] compares;

    hash_table_scoreboard sb = new();
    logic [KEY_W-1:0]     key_pool [$];
    int                   idle_pct = 35;
    int                   items_sent = 0;
    int                   size_writes = 0;
    int                   cycle_count = 0;

    linear_probe_hash_table_top #(
        .TABLE_DEPTH (DEPTH),
        .KEY_BYTES   (KEY_BYTES_USED)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .key      (key),
        .done     (done),
        .status   (status),
        .slot     (slot),
        .compares (compares)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(status, slot, compares);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding.",
                     cycle_count, sb.pending.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // A key of len nonzero bytes, then, if len is under 8, a terminating zero byte and random junk.
    function automatic logic [KEY_W-1:0] random_key(int len);
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        for (int b = 0; b < 8; b++) begin
            if (b < len) begin
                if (k[8*b +: 8] == 8'd0) k[8*b +: 8] = 8'($urandom_range(255, 1));
            end
            else if (b == len) begin
                k[8*b +: 8] = 8'd0;
            end
        end
        if (k == '0) k[KEY_W-1] = 1'b1;
        return k;
    endfunction

    // Same key with new junk past the terminator, or with two bytes swapped.
    function automatic logic [KEY_W-1:0] vary_key(logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] v;
        logic [7:0]       t;
        int               len;
        int               mode;
        v = raw;
        len = 8;
        for (int b = 7; b >= 0; b--) begin
            if (raw[8*b +: 8] == 8'd0) len = b;
        end
        mode = $urandom_range(2);
        if (mode == 1 && len <= 6) begin
            for (int b = len + 1; b < 8; b++) v[8*b +: 8] = 8'($urandom);
        end
        else if (mode == 2 && len >= 2) begin
            t = v[7:0];
            v[7:0] = v[8*(len-1) +: 8];
            v[8*(len-1) +: 8] = t;
        end
        if (v == '0) v[KEY_W-1] = 1'b1;
        return v;
    endfunction

    task automatic send_request(logic act, logic [KEY_W-1:0] raw);
        @(negedge clk);
        start <= 1'b1;
        action <= act;
        key <= raw;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(act, raw);
        items_sent++;
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
        action <= 1'($urandom);
        key <= {$urandom, $urandom};
    endtask

    task automatic maybe_idle();
        if ($urandom_range(99) < idle_pct) begin
            repeat ($urandom_range(6, 1)) idle_cycle();
        end
    endtask

    task automatic drain_table();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0 || busy !== 1'b0) @(negedge clk);
    endtask

    task automatic write_size(logic [SIZE_CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_data <= SIZE_CFG_W'($urandom);
        sb.set_size(value);
        size_writes++;
    endtask

    task automatic random_request(int find_pct);
        logic             act;
        logic [KEY_W-1:0] raw;
        int               pick;
        act = ($urandom_range(99) < find_pct) ? ACT_FIND : ACT_INSERT;
        pick = $urandom_range(99);
        if (key_pool.size() > 0 && pick < 45) begin
            raw = vary_key(key_pool[$urandom_range(key_pool.size() - 1)]);
        end
        else if (pick < 60) begin
            raw = {$urandom, $urandom};
            if (raw == '0) raw[0] = 1'b1;
        end
        else if (pick < 85) begin
            raw = random_key($urandom_range(3));
        end
        else begin
            raw = random_key($urandom_range(8));
        end
        if (act == ACT_INSERT) begin
            key_pool.push_back(raw);
            if (key_pool.size() > 48) void'(key_pool.pop_front());
        end
        maybe_idle();
        send_request(act, raw);
    endtask

    initial
    begin
        int phase_size [NPHASE] = '{0, 1, 2, 3, 5, 8, 13, 16, 31, 64, 100, 200, 7, 50,
                                    2047, 1025, 1024, 1};
        int phase_items [NPHASE] = '{30, 30, 50, 60, 80, 100, 120, 120, 150, 200, 200,
                                     200, 60, 200, 30, 30, 40, 20};
        int phase_find [NPHASE] = '{40, 40, 40, 45, 45, 45, 45, 45, 45, 45, 45, 40, 50,
                                    45, 15, 15, 20, 50};
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        action = 1'b0;
        key = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Key extremes, terminators, anagram chains and wraparound at full size.
        send_request(ACT_INSERT, 64'h0000_0000_0000_0001);
        send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0001);
        send_request(ACT_FIND,   64'h0000_0000_0000_0001);
        send_request(ACT_FIND,   64'h0000_0000_0000_FF00);
        send_request(ACT_INSERT, 64'h0000_0000_0000_FF00);
        send_request(ACT_FIND,   64'h0000_0000_00AB_CD00);
        send_request(ACT_INSERT, 64'h5A00_0000_0000_0001);
        send_request(ACT_INSERT, 64'h8000_0000_0000_0000);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0201);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0102);
        send_request(ACT_FIND,   64'h0000_0000_0000_0102);
        send_request(ACT_INSERT, 64'h0000_0000_0000_8080);
        send_request(ACT_INSERT, 64'h0000_0003_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h0000_0004_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h0000_0002_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h0000_00FF_02FF_FFFF);
        send_request(ACT_FIND,   64'h0000_00FF_02FF_FFFF);
        send_request(ACT_FIND,   64'h7F7F_7F7F_7F7F_7F7F);
        send_request(ACT_INSERT, 64'h7F7F_7F7F_7F7F_7F7F);

        for (int ph = 0; ph < NPHASE; ph++) begin
            drain_table();
            write_size(SIZE_CFG_W'(phase_size[ph]));
            idle_pct = (phase_size[ph] == 100) ? 0 : 35;
            for (int i = 0; i < phase_items[ph]; i++) random_request(phase_find[ph]);
        end

        drain_table();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d beats never arrived", sb.pending.size()));

        $display("Ran %0d inserts and finds over %0d table size settings, %0d results checked.",
                 items_sent, size_writes + 1, sb.results_checked);
        $display("Outcomes: %0d added, %0d present, %0d full, %0d found, %0d not found.",
                 sb.status_seen[ST_ADDED], sb.status_seen[ST_PRESENT], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_FOUND], sb.status_seen[ST_MISSING]);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
